// ===== rtl/i2cm_pkg.sv =====
// Shared types, command codes and constants for the I2C master byte engine.
`default_nettype none
package i2cm_pkg;

  localparam int BITS_PER_BYTE = 8;

  // Command codes, as carried on req_type and kept in the sequencer state
  localparam logic [2:0] CMD_IDLE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_STOP      = 3'd2;
  localparam logic [2:0] CMD_WRITE     = 3'd3;
  localparam logic [2:0] CMD_READ      = 3'd4;
  localparam logic [2:0] CMD_WAIT      = 3'd5;
  localparam logic [2:0] CMD_STOP_FAIL = 3'd6;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT  = 4'd1;

  localparam logic [7:0]  TICKS_PER_US_RST = 8'd1;
  localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd250;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_fail;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  phase;
    logic [3:0]  bit_cnt;
    logic [7:0]  shift;
    logic [11:0] delay;
    logic [15:0] tmo;
    logic        scl;
    logic        sda;
    logic        ack_choice;
    logic [7:0]  rx;
  } seq_state_t;

  typedef struct packed {
    logic [7:0]  ticks_per_us;
    logic [15:0] ack_timeout;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/i2c_master_byte_engine.sv =====
// Top level of the I2C master byte engine: handshakes, config and state registers.
//
// Usage:
//   Each transfer on the in_ channel is one bus tick. It carries the sampled
//   SDA level and, while the engine is idle, a command in req_type (start,
//   stop, write byte, read byte, wait ack). Commands arriving while busy are
//   ignored. Every accepted tick yields exactly one result transfer on the
//   out_ channel with the SCL/SDA levels to drive, busy, done, the last
//   received byte and the ack failure flag.
//   The result of a tick is registered and presented in the cycle after it is
//   accepted. Throughput: one tick per cycle; the sequencer update and the
//   result are computed in a single combinational pass from the state
//   registers into the output register.
//   Stall: when the receiver holds out_ready low, the output register holds
//   its transfer and in_ready drops, so no tick is lost or doubled.
//   Config: cfg_ writes are always ready; index 0 sets ticks per
//   microsecond, index 1 the ack timeout; other indexes are dropped.
//   Reset: rst_n is synchronous; the bus is released (SCL and SDA high),
//   the engine is idle and the config registers return to 1 and 250.
`default_nettype none
module i2c_master_byte_engine (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire i2cm_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output i2cm_pkg::out_item_t               out_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [i2cm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [15:0]                        cfg_data
);

  i2cm_pkg::seq_state_t st_r;
  i2cm_pkg::seq_state_t st_nxt;
  i2cm_pkg::cfg_t       cfg_r;
  i2cm_pkg::out_item_t  res_nxt;
  i2cm_pkg::out_item_t  out_data_r;
  logic                 out_valid_r;
  logic                 in_xfer;

  // Advance when the output register is empty or being drained this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  i2cm_step u_step (
    .cur     (st_r),
    .in_item (in_data),
    .cfg     (cfg_r),
    .nxt     (st_nxt),
    .res     (res_nxt)
  );

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_us <= i2cm_pkg::TICKS_PER_US_RST;
      cfg_r.ack_timeout  <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == i2cm_pkg::CFG_TICKS_PER_US) begin
        cfg_r.ticks_per_us <= cfg_data[7:0];
      end else if (cfg_index == i2cm_pkg::CFG_ACK_TIMEOUT) begin
        cfg_r.ack_timeout <= cfg_data;
      end
    end
  end

  // Sequencer state: advance by one tick per accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.cmd        <= i2cm_pkg::CMD_IDLE;
      st_r.phase      <= 4'd0;
      st_r.bit_cnt    <= 4'd0;
      st_r.shift      <= 8'd0;
      st_r.delay      <= 12'd0;
      st_r.tmo        <= 16'd0;
      st_r.scl        <= 1'b1;
      st_r.sda        <= 1'b1;
      st_r.ack_choice <= 1'b0;
      st_r.rx         <= 8'd0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // Output register: hold while stalled, load on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/i2cm_step.sv =====
// Next-state and result logic of the bit-level bus sequencer for one tick.
`default_nettype none
module i2cm_step (
  input  wire i2cm_pkg::seq_state_t cur,
  input  wire i2cm_pkg::in_item_t   in_item,
  input  wire i2cm_pkg::cfg_t       cfg,
  output i2cm_pkg::seq_state_t      nxt,
  output i2cm_pkg::out_item_t       res
);

  logic        run;
  logic        done;
  logic        fail;
  logic [3:0]  bit_inc;
  logic [11:0] d1;
  logic [11:0] d2;
  logic [11:0] d4;

  assign d1      = {4'd0, cfg.ticks_per_us};
  assign d2      = {3'd0, cfg.ticks_per_us, 1'b0};
  assign d4      = {2'd0, cfg.ticks_per_us, 2'b0};
  assign bit_inc = cur.bit_cnt + 4'd1;

  always_comb begin
    nxt  = cur;
    run  = 1'b0;
    done = 1'b0;
    fail = 1'b0;

    if (cur.delay != 12'd0) begin
      nxt.delay = cur.delay - 12'd1;
    end else if (cur.cmd == i2cm_pkg::CMD_IDLE) begin
      // Take a new command; reserved codes are dropped
      if (in_item.req_type >= i2cm_pkg::CMD_START &&
          in_item.req_type <= i2cm_pkg::CMD_WAIT) begin
        nxt.cmd     = in_item.req_type;
        nxt.phase   = 4'd0;
        nxt.bit_cnt = 4'd0;
        nxt.tmo     = 16'd0;
        nxt.shift   = (in_item.req_type == i2cm_pkg::CMD_WRITE) ? in_item.tx_byte : 8'd0;
        if (in_item.req_type == i2cm_pkg::CMD_READ) begin
          nxt.ack_choice = in_item.send_ack;
        end
        run = 1'b1;
      end
    end else begin
      run = 1'b1;
    end

    if (run) begin
      unique case (nxt.cmd)
        i2cm_pkg::CMD_START: begin
          if (nxt.phase == 4'd0) begin
            nxt.scl = 1'b1; nxt.sda = 1'b1; nxt.delay = d4; nxt.phase = 4'd1;
          end else if (nxt.phase == 4'd1) begin
            nxt.sda = 1'b0; nxt.delay = d4; nxt.phase = 4'd2;
          end else begin
            nxt.scl = 1'b0; nxt.cmd = i2cm_pkg::CMD_IDLE; nxt.phase = 4'd0; done = 1'b1;
          end
        end
        i2cm_pkg::CMD_STOP, i2cm_pkg::CMD_STOP_FAIL: begin
          if (nxt.phase == 4'd0) begin
            nxt.scl = 1'b0; nxt.sda = 1'b0; nxt.delay = d4; nxt.phase = 4'd1;
          end else if (nxt.phase == 4'd1) begin
            nxt.scl = 1'b1; nxt.sda = 1'b1; nxt.delay = d4; nxt.phase = 4'd2;
          end else begin
            fail      = (nxt.cmd == i2cm_pkg::CMD_STOP_FAIL);
            nxt.cmd   = i2cm_pkg::CMD_IDLE;
            nxt.phase = 4'd0;
            done      = 1'b1;
          end
        end
        i2cm_pkg::CMD_WRITE: begin
          if (nxt.phase == 4'd0) begin
            nxt.sda = nxt.shift[7]; nxt.delay = d2; nxt.phase = 4'd1;
          end else if (nxt.phase == 4'd1) begin
            nxt.scl = 1'b1; nxt.delay = d2; nxt.phase = 4'd2;
          end else if (nxt.phase == 4'd2) begin
            nxt.scl = 1'b0;
            // Release SDA after the last data bit so the slave can ack
            if (cur.bit_cnt == 4'(i2cm_pkg::BITS_PER_BYTE - 1)) begin
              nxt.sda = 1'b1;
            end
            nxt.shift   = {nxt.shift[6:0], 1'b0};
            nxt.delay   = d4;
            nxt.bit_cnt = bit_inc;
            nxt.phase   = (bit_inc >= 4'(i2cm_pkg::BITS_PER_BYTE)) ? 4'd3 : 4'd0;
          end else begin
            nxt.cmd = i2cm_pkg::CMD_IDLE; nxt.phase = 4'd0; done = 1'b1;
          end
        end
        i2cm_pkg::CMD_READ: begin
          if (nxt.phase == 4'd0) begin
            nxt.scl = 1'b0; nxt.sda = 1'b1; nxt.delay = d2; nxt.phase = 4'd1;
          end else if (nxt.phase == 4'd1) begin
            nxt.scl     = 1'b1;
            nxt.shift   = {nxt.shift[6:0], in_item.sda_in};
            nxt.delay   = d1;
            nxt.bit_cnt = bit_inc;
            nxt.phase   = (bit_inc >= 4'(i2cm_pkg::BITS_PER_BYTE)) ? 4'd2 : 4'd0;
          end else if (nxt.phase == 4'd2) begin
            nxt.scl = 1'b0; nxt.delay = d2; nxt.phase = 4'd3;
          end else if (nxt.phase == 4'd3) begin
            nxt.sda = ~nxt.ack_choice; nxt.delay = d2; nxt.phase = 4'd4;
          end else if (nxt.phase == 4'd4) begin
            nxt.scl = 1'b1; nxt.delay = d2; nxt.phase = 4'd5;
          end else begin
            nxt.scl   = 1'b0;
            nxt.rx    = nxt.shift;
            nxt.cmd   = i2cm_pkg::CMD_IDLE;
            nxt.phase = 4'd0;
            done      = 1'b1;
          end
        end
        i2cm_pkg::CMD_WAIT: begin
          if (nxt.phase == 4'd0) begin
            nxt.sda = 1'b1; nxt.delay = d1; nxt.phase = 4'd1;
          end else if (nxt.phase == 4'd1) begin
            nxt.scl = 1'b1; nxt.tmo = 16'd0; nxt.delay = d1; nxt.phase = 4'd2;
          end else if (!in_item.sda_in) begin
            nxt.scl = 1'b0; nxt.cmd = i2cm_pkg::CMD_IDLE; nxt.phase = 4'd0; done = 1'b1;
          end else if (nxt.tmo == cfg.ack_timeout) begin
            nxt.cmd   = i2cm_pkg::CMD_STOP_FAIL;
            nxt.phase = 4'd0;
          end else begin
            nxt.tmo = nxt.tmo + 16'd1;
          end
        end
        default: begin
          nxt.cmd = i2cm_pkg::CMD_IDLE; nxt.phase = 4'd0; done = 1'b1;
        end
      endcase
    end

    res.scl_level = nxt.scl;
    res.sda_level = nxt.sda;
    res.busy_res  = (nxt.cmd != i2cm_pkg::CMD_IDLE);
    res.done_res  = done;
    res.rx_byte   = nxt.rx;
    res.ack_fail  = fail;
  end

endmodule
`default_nettype wire

// ===== rtl/i2cm_checker.sv =====
// Port-level checker for the I2C master byte engine, bound to the top level.
`default_nettype none
module i2cm_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire i2cm_pkg::out_item_t out_data
);

  // A stalled result holds its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Every accepted tick shows a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result");

  // The engine takes a tick whenever its output side can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output register");

  // A completing command leaves the engine idle; a failure is a completion
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.done_res || out_data.ack_fail) |->
      out_data.done_res && !out_data.busy_res)
    else $error("done or ack_fail inconsistent with busy");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the I2C master byte engine: per-tick results against a predictor.
module tb;
  import i2cm_pkg::*;

  // Codes 6 and 7 on req_type are not commands; the engine treats them as no request.
  localparam logic [2:0] REQ_SPARE_SIX   = CMD_STOP_FAIL;
  localparam logic [2:0] REQ_SPARE_SEVEN = 3'd7;
  // An index the engine has no register for.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'hF;
  // Tick index at which the slave pulls SDA low; this one means never.
  localparam int unsigned SDA_HELD_HIGH = 32'hFFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Predictor copy of the sequencer state and the register file.
  seq_state_t  eng;
  cfg_t        bus_cfg;
  logic        tick_done;
  logic        tick_fail;

  // Results expected for each accepted tick, oldest first.
  out_item_t   pending_bus_out[$];
  out_item_t   want_r;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned commands_done = 0;
  int unsigned reads_issued = 0;
  int unsigned ack_timeouts = 0;
  int unsigned reg_writes = 0;

  i2c_master_byte_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("i2c_master_byte_engine test failed");
      $finish;
    end
  end

  // Receiver: stall out_ready at the current rate, changing only on the falling edge.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_model();
    eng = '0;
    eng.cmd = CMD_IDLE;
    eng.scl = 1'b1;
    eng.sda = 1'b1;
    bus_cfg.ticks_per_us = TICKS_PER_US_RST;
    bus_cfg.ack_timeout  = ACK_TIMEOUT_RST;
  endfunction

  // Load a phase delay of some microseconds, wrapped to the 12-bit counter.
  function automatic void load_delay(input int unsigned us);
    eng.delay = 12'(us * bus_cfg.ticks_per_us);
  endfunction

  function automatic void end_command();
    eng.cmd   = CMD_IDLE;
    eng.phase = '0;
    tick_done = 1'b1;
  endfunction

  // Run one phase of the active command; sda_bit is the line level sampled this tick.
  function automatic void advance_phase(input logic sda_bit);
    case (eng.cmd)
      CMD_START: begin
        if (eng.phase == 0) begin
          eng.scl = 1'b1; eng.sda = 1'b1; load_delay(4); eng.phase = 4'd1;
        end else if (eng.phase == 1) begin
          eng.sda = 1'b0; load_delay(4); eng.phase = 4'd2;
        end else begin
          eng.scl = 1'b0; end_command();
        end
      end
      CMD_STOP, CMD_STOP_FAIL: begin
        if (eng.phase == 0) begin
          eng.scl = 1'b0; eng.sda = 1'b0; load_delay(4); eng.phase = 4'd1;
        end else if (eng.phase == 1) begin
          eng.scl = 1'b1; eng.sda = 1'b1; load_delay(4); eng.phase = 4'd2;
        end else begin
          if (eng.cmd == CMD_STOP_FAIL) tick_fail = 1'b1;
          end_command();
        end
      end
      CMD_WRITE: begin
        if (eng.phase == 0) begin
          eng.sda = eng.shift[7]; load_delay(2); eng.phase = 4'd1;
        end else if (eng.phase == 1) begin
          eng.scl = 1'b1; load_delay(2); eng.phase = 4'd2;
        end else if (eng.phase == 2) begin
          // Release SDA after the last data bit so the slave can acknowledge.
          eng.scl = 1'b0;
          if (eng.bit_cnt == 4'(BITS_PER_BYTE - 1)) eng.sda = 1'b1;
          eng.shift = {eng.shift[6:0], 1'b0};
          load_delay(4);
          eng.bit_cnt = eng.bit_cnt + 4'd1;
          eng.phase = (eng.bit_cnt >= 4'(BITS_PER_BYTE)) ? 4'd3 : 4'd0;
        end else begin
          end_command();
        end
      end
      CMD_READ: begin
        if (eng.phase == 0) begin
          eng.scl = 1'b0; eng.sda = 1'b1; load_delay(2); eng.phase = 4'd1;
        end else if (eng.phase == 1) begin
          eng.scl = 1'b1;
          eng.shift = {eng.shift[6:0], sda_bit};
          load_delay(1);
          eng.bit_cnt = eng.bit_cnt + 4'd1;
          eng.phase = (eng.bit_cnt >= 4'(BITS_PER_BYTE)) ? 4'd2 : 4'd0;
        end else if (eng.phase == 2) begin
          eng.scl = 1'b0; load_delay(2); eng.phase = 4'd3;
        end else if (eng.phase == 3) begin
          eng.sda = eng.ack_choice ? 1'b0 : 1'b1; load_delay(2); eng.phase = 4'd4;
        end else if (eng.phase == 4) begin
          eng.scl = 1'b1; load_delay(2); eng.phase = 4'd5;
        end else begin
          eng.scl = 1'b0; eng.rx = eng.shift; end_command();
        end
      end
      CMD_WAIT: begin
        if (eng.phase == 0) begin
          eng.sda = 1'b1; load_delay(1); eng.phase = 4'd1;
        end else if (eng.phase == 1) begin
          eng.scl = 1'b1; eng.tmo = '0; load_delay(1); eng.phase = 4'd2;
        end else if (sda_bit == 1'b0) begin
          eng.scl = 1'b0; end_command();
        end else if (eng.tmo == bus_cfg.ack_timeout) begin
          // No answer in time: fall into a stop that flags the failure.
          eng.cmd = CMD_STOP_FAIL;
          eng.phase = '0;
        end else begin
          eng.tmo = eng.tmo + 16'd1;
        end
      end
      default: end_command();
    endcase
  endfunction

  // Advance the predictor by one tick and return the result the engine reports for it.
  function automatic out_item_t sequence_tick(input in_item_t tick);
    out_item_t r;
    tick_done = 1'b0;
    tick_fail = 1'b0;
    if (eng.delay != 0) begin
      eng.delay = eng.delay - 12'd1;
    end else if (eng.cmd == CMD_IDLE) begin
      if (tick.req_type >= CMD_START && tick.req_type <= CMD_WAIT) begin
        eng.cmd     = tick.req_type;
        eng.phase   = '0;
        eng.bit_cnt = '0;
        eng.tmo     = '0;
        eng.shift   = (tick.req_type == CMD_WRITE) ? tick.tx_byte : 8'h00;
        if (tick.req_type == CMD_READ) eng.ack_choice = tick.send_ack;
        advance_phase(tick.sda_in);
      end
    end else begin
      advance_phase(tick.sda_in);
    end
    r.scl_level = eng.scl;
    r.sda_level = eng.sda;
    r.busy_res  = (eng.cmd != CMD_IDLE);
    r.done_res  = tick_done;
    r.rx_byte   = eng.rx;
    r.ack_fail  = tick_fail;
    return r;
  endfunction

  function automatic bit engine_busy();
    return (eng.cmd != CMD_IDLE) || (eng.delay != 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Compare every result transfer with the oldest expected tick.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_bus_out.size() == 0) begin
        $error("result transfer with no tick outstanding");
        mismatches++;
      end else begin
        want_r = pending_bus_out.pop_front();
        check_field("scl_level", 8'(want_r.scl_level), 8'(out_data.scl_level));
        check_field("sda_level", 8'(want_r.sda_level), 8'(out_data.sda_level));
        check_field("busy_res",  8'(want_r.busy_res),  8'(out_data.busy_res));
        check_field("done_res",  8'(want_r.done_res),  8'(out_data.done_res));
        check_field("rx_byte",   want_r.rx_byte,       out_data.rx_byte);
        check_field("ack_fail",  8'(want_r.ack_fail),  8'(out_data.ack_fail));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_tick(input logic [2:0] req, input logic [7:0] tx,
                                         input logic ack, input logic sda_bit);
    in_item_t t;
    t.req_type = req;
    t.tx_byte  = tx;
    t.send_ack = ack;
    t.sda_in   = sda_bit;
    return t;
  endfunction

  // Offer one tick on the falling edge, possibly after idle cycles, and hold it
  // until the transfer. Valid is left high; callers that wait drop it first.
  task automatic send_tick(input in_item_t tick);
    out_item_t r;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = tick;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = sequence_tick(tick);
    pending_bus_out.push_back(r);
    ticks_sent++;
    if (r.done_res) commands_done++;
    if (r.ack_fail) ack_timeouts++;
  endtask

  // Issue one request on an idle engine, then keep ticking until it is idle
  // again. Filler ticks sometimes carry stray commands, which must be dropped.
  // SDA goes low from tick sda_low_at on; before that it is high or random.
  task automatic run_command(input logic [2:0] req, input logic [7:0] tx, input logic ack,
                             input int unsigned sda_low_at, input bit sda_noisy);
    int unsigned k;
    logic        sda_bit;
    logic [2:0]  stray;
    k = 0;
    if (req == CMD_READ) reads_issued++;
    while (k == 0 || engine_busy()) begin
      sda_bit = (k >= sda_low_at) ? 1'b0 : (sda_noisy ? 1'($urandom_range(1)) : 1'b1);
      if (k == 0) begin
        send_tick(make_tick(req, tx, ack, sda_bit));
      end else begin
        stray = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : CMD_IDLE;
        send_tick(make_tick(stray, 8'($urandom), 1'($urandom_range(1)), sda_bit));
      end
      k++;
    end
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_bus_out.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write; only called with the engine drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_TICKS_PER_US) bus_cfg.ticks_per_us = value[7:0];
    else if (idx == CFG_ACK_TIMEOUT) bus_cfg.ack_timeout = value;
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_bus_timing(input logic [7:0] tpu, input logic [15:0] timeout);
    wait_drained();
    // Upper data bits are junk for the 8-bit register and must be dropped.
    write_reg(CFG_TICKS_PER_US, {8'($urandom), tpu});
    write_reg(CFG_ACK_TIMEOUT, timeout);
  endtask

  // Slave answer point for a wait ack: mostly inside the poll window, sometimes never.
  function automatic int unsigned ack_delay();
    if ($urandom_range(4) == 0) return SDA_HELD_HIGH;
    return $urandom_range(0, 2 * bus_cfg.ticks_per_us + 4 + bus_cfg.ack_timeout);
  endfunction

  // A full bus transaction: start, address, ack, data bytes, stop.
  task automatic random_transaction();
    int unsigned n;
    run_command(CMD_START, 8'($urandom), 1'($urandom_range(1)), SDA_HELD_HIGH, 1'b1);
    run_command(CMD_WRITE, 8'($urandom), 1'($urandom_range(1)), SDA_HELD_HIGH, 1'b1);
    run_command(CMD_WAIT, 8'($urandom), 1'($urandom_range(1)), ack_delay(), 1'b0);
    n = $urandom_range(1, 3);
    repeat (n) begin
      if ($urandom_range(1)) begin
        run_command(CMD_WRITE, 8'($urandom), 1'($urandom_range(1)), SDA_HELD_HIGH, 1'b1);
        run_command(CMD_WAIT, 8'($urandom), 1'($urandom_range(1)), ack_delay(), 1'b0);
      end else begin
        run_command(CMD_READ, 8'($urandom), 1'($urandom_range(1)), SDA_HELD_HIGH, 1'b1);
      end
    end
    run_command(CMD_STOP, 8'($urandom), 1'($urandom_range(1)), SDA_HELD_HIGH, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Released bus after reset; spare request codes leave the engine idle.
  task automatic test_idle_bus();
    run_command(CMD_IDLE, 8'hFF, 1'b1, SDA_HELD_HIGH, 1'b1);
    run_command(REQ_SPARE_SIX, 8'h00, 1'b0, 0, 1'b0);
    run_command(REQ_SPARE_SEVEN, 8'h5A, 1'b1, SDA_HELD_HIGH, 1'b0);
  endtask

  // Start, byte writes at the data extremes, stop, at the reset timing.
  task automatic test_write_bytes();
    run_command(CMD_START, 8'h00, 1'b0, SDA_HELD_HIGH, 1'b1);
    run_command(CMD_WRITE, 8'h00, 1'b0, SDA_HELD_HIGH, 1'b1);
    run_command(CMD_WRITE, 8'hFF, 1'b1, SDA_HELD_HIGH, 1'b1);
    run_command(CMD_STOP, 8'h00, 1'b0, SDA_HELD_HIGH, 1'b1);
  endtask

  // Reads of all ones and all zeros, with ACK and with NACK, then a random byte.
  task automatic test_read_bytes();
    run_command(CMD_READ, 8'h00, 1'b1, SDA_HELD_HIGH, 1'b0);
    run_command(CMD_READ, 8'hFF, 1'b0, 0, 1'b0);
    run_command(CMD_READ, 8'h3C, 1'b1, SDA_HELD_HIGH, 1'b1);
  endtask

  // Slave ACK in time, no ACK at the reset timeout, zero timeout,
  // a timeout past eight bits, and the largest timeout answered late.
  task automatic test_ack_wait();
    run_command(CMD_WAIT, 8'h00, 1'b0, 5, 1'b0);
    run_command(CMD_WAIT, 8'h00, 1'b0, SDA_HELD_HIGH, 1'b0);
    set_bus_timing(8'd1, 16'd0);
    run_command(CMD_WAIT, 8'h00, 1'b0, SDA_HELD_HIGH, 1'b0);
    set_bus_timing(8'd1, 16'd256);
    run_command(CMD_WAIT, 8'h00, 1'b0, SDA_HELD_HIGH, 1'b0);
    set_bus_timing(8'd1, 16'hFFFF);
    run_command(CMD_WAIT, 8'h00, 1'b0, 60, 1'b0);
  endtask

  // Prescaler extremes: zero means one tick per phase, 255 the slowest bus.
  task automatic test_prescaler_extremes();
    set_bus_timing(8'd0, 16'd3);
    run_command(CMD_START, 8'h00, 1'b0, SDA_HELD_HIGH, 1'b1);
    run_command(CMD_WRITE, 8'h96, 1'b0, SDA_HELD_HIGH, 1'b1);
    run_command(CMD_WAIT, 8'h00, 1'b0, SDA_HELD_HIGH, 1'b0);
    // Shortest command on the slowest bus: a wait ack the slave answers at once.
    set_bus_timing(8'd255, 16'd3);
    run_command(CMD_WAIT, 8'h00, 1'b0, 0, 1'b0);
    // A write to a missing register must change nothing.
    set_bus_timing(8'd1, 16'd3);
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    run_command(CMD_READ, 8'h00, 1'b1, SDA_HELD_HIGH, 1'b1);
  endtask

  // Mostly well-formed traffic with random content, some single commands,
  // some noise, and timing changes between them.
  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned tick_goal);
    int unsigned first;
    int unsigned pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    set_bus_timing(8'($urandom_range(0, 2)), 16'($urandom_range(0, 24)));
    first = ticks_sent;
    while (ticks_sent - first < tick_goal) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        random_transaction();
      end else if (pick < 80) begin
        run_command(3'($urandom_range(CMD_START, CMD_WAIT)), 8'($urandom),
                    1'($urandom_range(1)), ack_delay(), 1'($urandom_range(1)));
      end else if (pick < 90) begin
        repeat ($urandom_range(3, 12))
          run_command(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                      $urandom_range(0, 20), 1'b1);
      end else begin
        // Mostly fast timing; now and then a slower bus.
        set_bus_timing(($urandom_range(9) == 0) ? 8'($urandom_range(3, 5))
                                                : 8'($urandom_range(0, 2)),
                       16'($urandom_range(0, 24)));
      end
    end
  endtask

  initial begin
    reset_model();
    // Hold reset from time zero, release it on a falling edge.
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    tx_idle_pct = 34;
    rx_idle_pct = 70;
    test_idle_bus();
    test_write_bytes();
    test_read_bytes();
    test_ack_wait();
    test_prescaler_extremes();

    test_random_traffic(34, 70, 50);
    test_random_traffic(70, 34, 50);
    test_random_traffic(0, 0, 50);

    wait_drained();
    $display("covered %0d ticks, %0d completed commands, %0d reads, %0d ack timeouts",
             ticks_sent, commands_done, reads_issued, ack_timeouts);
    $display("through %0d register writes and three sender/receiver stall patterns",
             reg_writes);
    if (mismatches == 0 && pending_bus_out.size() == 0) begin
      $display("i2c_master_byte_engine test passed");
    end else begin
      $display("i2c_master_byte_engine test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_step.sv
rtl/i2c_master_byte_engine.sv
rtl/i2cm_checker.sv
bench/tb.sv
